FILE: rtl/rme_pkg.sv
`default_nettype none
package rme_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int CW = 36;
	localparam int ORTHO_LAT = 6;
	localparam int SQRT_LAT = 32;
	localparam int CORDIC_LAT = CORDIC_STAGES + 2;
	localparam int TOTAL_LAT = ORTHO_LAT + SQRT_LAT + CORDIC_LAT + 1;

	localparam logic signed [32:0] DEG90 = 33'sd754974720;
	localparam logic signed [32:0] DEG180 = 33'sd1509949440;

	typedef enum logic {
		REG_ORTHO_TOL = 1'b0,
		REG_SING_THR = 1'b1
	} reg_idx_t;

	typedef logic signed [31:0] elem_t;

	typedef struct packed {
		logic signed [32:0] roll_y;
		logic signed [32:0] roll_x;
		logic signed [32:0] yaw_y;
		logic signed [32:0] yaw_x;
		logic signed [32:0] pitch_y;
		logic               sing;
		logic               notrot;
	} pay_t;

	typedef struct packed {
		logic sing;
		logic notrot;
	} flags_t;

	function automatic logic signed [32:0] atan_deg(input int i);
		logic signed [32:0] r;
		unique case (i)
			0: r = 33'sd377487360;
			1: r = 33'sd222843801;
			2: r = 33'sd117744544;
			3: r = 33'sd59768969;
			4: r = 33'sd30000467;
			5: r = 33'sd15014858;
			6: r = 33'sd7509261;
			7: r = 33'sd3754860;
			8: r = 33'sd1877459;
			9: r = 33'sd938733;
			10: r = 33'sd469367;
			11: r = 33'sd234683;
			12: r = 33'sd117342;
			13: r = 33'sd58671;
			14: r = 33'sd29335;
			15: r = 33'sd14668;
			16: r = 33'sd7334;
			17: r = 33'sd3667;
			18: r = 33'sd1833;
			19: r = 33'sd917;
			20: r = 33'sd458;
			21: r = 33'sd229;
			22: r = 33'sd115;
			23: r = 33'sd57;
			24: r = 33'sd29;
			25: r = 33'sd14;
			26: r = 33'sd7;
			27: r = 33'sd4;
			28: r = 33'sd2;
			29: r = 33'sd1;
			default: r = 33'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rme_ortho.sv
`default_nettype none
module rme_ortho (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire rme_pkg::elem_t  m [9],
	input  wire logic [31:0]     tol,
	input  wire logic [31:0]     thr,
	output rme_pkg::pay_t        pay_o,
	output logic [63:0]          sy2_o
);
	import rme_pkg::*;

	localparam int PI [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};

	logic signed [63:0] prod_s1 [6][3];
	logic signed [35:0] d_s2 [6];
	logic [30:0]        ad_s3 [6];
	logic [61:0]        sq_s4 [6];
	logic [63:0]        err_s5;
	elem_t m_s1 [9], m_s2 [9], m_s3 [9], m_s4 [9], m_s5 [9];
	logic [63:0] sy2_s2, sy2_s3, sy2_s4, sy2_s5;
	logic sing_s3, sing_s4, sing_s5;

	function automatic logic signed [32:0] ext(input elem_t v);
		return {v[31], v};
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 6; p++)
				for (int k = 0; k < 3; k++)
					prod_s1[p][k] <= 64'(m[k*3+PI[p]]) * 64'(m[k*3+PJ[p]]);
			m_s1 <= m;

			for (int p = 0; p < 6; p++) begin
				logic signed [63:0] s;
				s = (prod_s1[p][0] >>> 30) + (prod_s1[p][1] >>> 30)
					+ (prod_s1[p][2] >>> 30);
				if (PI[p] == PJ[p])
					s = s - 64'sd1073741824;
				d_s2[p] <= s[35:0];
			end
			sy2_s2 <= 64'(prod_s1[0][0]) + 64'(prod_s1[0][1]);
			m_s2 <= m_s1;

			for (int p = 0; p < 6; p++) begin
				logic [35:0] a;
				a = d_s2[p][35] ? 36'(-d_s2[p]) : 36'(d_s2[p]);
				ad_s3[p] <= (a > 36'd1073741824) ? 31'd1073741824 : a[30:0];
			end
			sing_s3 <= sy2_s2 < {20'd0, thr, 12'd0};
			sy2_s3 <= sy2_s2;
			m_s3 <= m_s2;

			for (int p = 0; p < 6; p++)
				sq_s4[p] <= 62'(ad_s3[p]) * 62'(ad_s3[p]);
			sing_s4 <= sing_s3;
			sy2_s4 <= sy2_s3;
			m_s4 <= m_s3;

			err_s5 <= 64'(sq_s4[0]) + 64'(sq_s4[3]) + 64'(sq_s4[5])
				+ ((64'(sq_s4[1]) + 64'(sq_s4[2]) + 64'(sq_s4[4])) << 1);
			sing_s5 <= sing_s4;
			sy2_s5 <= sy2_s4;
			m_s5 <= m_s4;

			pay_o.notrot <= err_s5 > {20'd0, tol, 12'd0};
			pay_o.sing <= sing_s5;
			pay_o.roll_y <= sing_s5 ? -ext(m_s5[5]) : ext(m_s5[7]);
			pay_o.roll_x <= sing_s5 ? ext(m_s5[4]) : ext(m_s5[8]);
			pay_o.yaw_y <= ext(m_s5[3]);
			pay_o.yaw_x <= ext(m_s5[0]);
			pay_o.pitch_y <= -ext(m_s5[6]);
			sy2_o <= sy2_s5;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rme_isqrt.sv
`default_nettype none
module rme_isqrt (
	input  wire logic     clk,
	input  wire logic     en,
	input  wire rme_pkg::pay_t pay_i,
	input  wire logic [63:0] sy2_i,
	output rme_pkg::pay_t pay_o,
	output logic [31:0]   sy_o
);
	import rme_pkg::*;

	logic [63:0] v_in [SQRT_LAT];
	logic [63:0] r_in [SQRT_LAT];
	pay_t        p_in [SQRT_LAT];
	logic [63:0] v_s [SQRT_LAT];
	logic [63:0] r_s [SQRT_LAT];
	pay_t        p_s [SQRT_LAT];

	always_comb begin
		v_in[0] = sy2_i;
		r_in[0] = 64'd0;
		p_in[0] = pay_i;
		for (int k = 1; k < SQRT_LAT; k++) begin
			v_in[k] = v_s[k-1];
			r_in[k] = r_s[k-1];
			p_in[k] = p_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_LAT; k++) begin
				logic [63:0] b;
				b = 64'd1 << (62 - 2 * k);
				if (v_in[k] >= r_in[k] + b) begin
					v_s[k] <= v_in[k] - (r_in[k] + b);
					r_s[k] <= (r_in[k] >> 1) + b;
				end else begin
					v_s[k] <= v_in[k];
					r_s[k] <= r_in[k] >> 1;
				end
				p_s[k] <= p_in[k];
			end
		end
	end

	assign pay_o = p_s[SQRT_LAT-1];
	assign sy_o = r_s[SQRT_LAT-1][31:0];
endmodule
`default_nettype wire

FILE: rtl/rme_cordic.sv
`default_nettype none
module rme_cordic (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [32:0] y_in,
	input  wire logic signed [32:0] x_in,
	output logic signed [31:0]      z_out
);
	import rme_pkg::*;

	logic signed [CW-1:0] x_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] y_s [CORDIC_STAGES+1];
	logic signed [32:0]   z_s [CORDIC_STAGES+1];
	logic                 zf_s [CORDIC_STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			zf_s[0] <= (x_in == 33'sd0) && (y_in == 33'sd0);
			if (x_in[32] && !y_in[32]) begin
				x_s[0] <= CW'(y_in);
				y_s[0] <= -CW'(x_in);
				z_s[0] <= DEG90;
			end else if (x_in[32]) begin
				x_s[0] <= -CW'(y_in);
				y_s[0] <= CW'(x_in);
				z_s[0] <= -DEG90;
			end else begin
				x_s[0] <= CW'(x_in);
				y_s[0] <= CW'(y_in);
				z_s[0] <= 33'sd0;
			end
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_deg(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_deg(i);
				end
				zf_s[i+1] <= zf_s[i];
			end
			if (zf_s[CORDIC_STAGES])
				z_out <= 32'sd0;
			else if (z_s[CORDIC_STAGES] > DEG180)
				z_out <= DEG180[31:0];
			else if (z_s[CORDIC_STAGES] < -DEG180)
				z_out <= 32'(-DEG180);
			else
				z_out <= z_s[CORDIC_STAGES][31:0];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rotation_matrix_to_euler.sv
// ZYX Euler angles from a 3x3 rotation matrix of signed Q1.30 elements.
// The input channel takes one matrix per beat (in_valid/in_stall), the
// output channel gives roll, pitch and yaw in signed Q8.23 degrees plus
// the singular and not_rotation flags (out_valid/out_stall).
// The block is a single pipeline that takes a new matrix every cycle while
// in_stall is low. Stages in order: the orthogonality check, a square root
// of r00^2 + r10^2 unrolled over its result bits, then three CORDIC lanes
// side by side, each with an input rotation, one stage per iteration and an
// output clamp, and a final merge stage that applies the flags.
// When the output beat is stalled the whole pipeline holds and in_stall
// rises; empty slots hold as well, so bubbles stay where they are.
// Reset clears the valid bits and sets both thresholds to 281.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once
// and are meant for times when no matrix is in flight.
`default_nettype none
module rotation_matrix_to_euler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic signed [31:0] r00,
	input  wire logic signed [31:0] r01,
	input  wire logic signed [31:0] r02,
	input  wire logic signed [31:0] r10,
	input  wire logic signed [31:0] r11,
	input  wire logic signed [31:0] r12,
	input  wire logic signed [31:0] r20,
	input  wire logic signed [31:0] r21,
	input  wire logic signed [31:0] r22,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] roll_deg,
	output logic signed [31:0] pitch_deg,
	output logic signed [31:0] yaw_deg,
	output logic             singular,
	output logic             not_rotation
);
	import rme_pkg::*;

	logic [31:0] tol_q, thr_q;
	logic [TOTAL_LAT-1:0] vld_q;
	logic en;
	elem_t m [9];
	pay_t pay_o, pay_r;
	logic [63:0] sy2;
	logic [31:0] sy;
	flags_t fl_q [CORDIC_LAT];
	logic signed [31:0] roll_z, pitch_z, yaw_z;

	assign en = !(vld_q[TOTAL_LAT-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[TOTAL_LAT-1];

	always_comb begin
		m[0] = r00; m[1] = r01; m[2] = r02;
		m[3] = r10; m[4] = r11; m[5] = r12;
		m[6] = r20; m[7] = r21; m[8] = r22;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 32'd281;
			thr_q <= 32'd281;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ORTHO_TOL: tol_q <= cfg_data;
				REG_SING_THR: thr_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[TOTAL_LAT-2:0], in_valid};
	end

	rme_ortho u_ortho (
		.clk(clk), .en(en), .m(m), .tol(tol_q), .thr(thr_q),
		.pay_o(pay_o), .sy2_o(sy2)
	);

	rme_isqrt u_isqrt (
		.clk(clk), .en(en), .pay_i(pay_o), .sy2_i(sy2),
		.pay_o(pay_r), .sy_o(sy)
	);

	rme_cordic u_roll (
		.clk(clk), .en(en), .y_in(pay_r.roll_y), .x_in(pay_r.roll_x), .z_out(roll_z)
	);

	rme_cordic u_pitch (
		.clk(clk), .en(en), .y_in(pay_r.pitch_y), .x_in({1'b0, sy}), .z_out(pitch_z)
	);

	rme_cordic u_yaw (
		.clk(clk), .en(en), .y_in(pay_r.yaw_y), .x_in(pay_r.yaw_x), .z_out(yaw_z)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			fl_q[0] <= '{sing: pay_r.sing, notrot: pay_r.notrot};
			for (int i = 1; i < CORDIC_LAT; i++)
				fl_q[i] <= fl_q[i-1];
			if (fl_q[CORDIC_LAT-1].notrot) begin
				roll_deg <= 32'sd0;
				pitch_deg <= 32'sd0;
				yaw_deg <= 32'sd0;
				singular <= 1'b0;
				not_rotation <= 1'b1;
			end else begin
				roll_deg <= roll_z;
				pitch_deg <= pitch_z;
				yaw_deg <= fl_q[CORDIC_LAT-1].sing ? 32'sd0 : yaw_z;
				singular <= fl_q[CORDIC_LAT-1].sing;
				not_rotation <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
